// ===== design/wpa_pkg.sv =====
package wpa_pkg;

   localparam int SAMPLE_W = 32;
   localparam int STEP_W = 16;
   localparam int DECADE_W = 34;
   localparam int PROD_W = DECADE_W + STEP_W;
   localparam int SCALE_W = 48;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W = 16;

   localparam logic [DECADE_W-1:0] DECADE_LOG_START = DECADE_W'(1);
   localparam logic [DECADE_W-1:0] DECADE_LIN_START = DECADE_W'(10000);
   localparam logic [DECADE_W-1:0] DECADE_CAP = DECADE_W'(64'd10000000000);
   localparam logic [SCALE_W-1:0] SCALE_MAX = {SCALE_W{1'b1}};

   localparam logic [CSR_INDEX_W-1:0] CSR_LOG_DETECTOR = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_LOW = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_MID = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_HIGH = CSR_INDEX_W'(3);

   typedef struct packed {
      logic log_detector;
      logic [STEP_W-1:0] range_low;
      logic [STEP_W-1:0] range_mid;
      logic [STEP_W-1:0] range_high;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      log_detector: 1'b1,
      range_low: STEP_W'(1),
      range_mid: STEP_W'(2),
      range_high: STEP_W'(5)
   };

endpackage

// ===== design/window_peak_autorange_core.sv =====
// Peak-hold autoranging core for a power meter display.
// Samples in microwatts enter through a queue-style port: a sample transfers
// when push is high and full is low. Each sample is written into a ring of the
// last WINDOW_SIZE samples, the ring is scanned for its peak, and the back end
// picks a full-scale value from that peak and the three range steps.
// Results leave through a queue-style port: while empty is low the oldest result
// sits on rsp_scale_uw and rsp_peak_uw and transfers when pop is high.
//
// The front end scans the ring through the single read port of its RAM and
// holds full high until it has pushed the peak into the queue, so it takes a
// new sample only after it is through with the last one. The back end spends a
// multiply and a check on each decade step of the search on its shared
// multiplier. A two-entry queue between them lets both run at once.
//
// Reset marks the ring empty (slots not yet written are skipped), sets the write
// position to zero and loads the register defaults. When the receiver stalls the
// result stays in the output register, the back end and then the queue fill,
// and full rises; no result is lost. The user must write configuration through
// valid, ready, csr_index and csr_data only while the core is idle (unenforced).
module window_peak_autorange_core #(
   parameter int WINDOW_SIZE = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic [wpa_pkg::SAMPLE_W-1:0]    req_sample_uw,
   output logic                            empty,
   input  logic                            pop,
   output logic [wpa_pkg::SCALE_W-1:0]     rsp_scale_uw,
   output logic [wpa_pkg::SAMPLE_W-1:0]    rsp_peak_uw,
   input  logic                            valid,
   output logic                            ready,
   input  logic [wpa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [wpa_pkg::CSR_DATA_W-1:0]  csr_data
);
   import wpa_pkg::*;

   cfg_type cfg_ff, cfg_in;

   logic q_push;
   logic q_full;
   logic [SAMPLE_W-1:0] q_in_peak;
   logic q_pop;
   logic q_empty;
   logic [SAMPLE_W-1:0] q_out_peak;

   // Register writes are always taken; indexes beyond the list are ignored.
   assign ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (valid) begin
         unique case (csr_index)
            CSR_LOG_DETECTOR: cfg_in.log_detector = csr_data[0];
            CSR_RANGE_LOW:    cfg_in.range_low = csr_data;
            CSR_RANGE_MID:    cfg_in.range_mid = csr_data;
            CSR_RANGE_HIGH:   cfg_in.range_high = csr_data;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end stores the sample and finds the window peak.
   wpa_front #(
      .WINDOW_SIZE(WINDOW_SIZE)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .sample_uw(req_sample_uw),
      .q_push   (q_push),
      .q_full   (q_full),
      .q_peak   (q_in_peak)
   );

   // Peaks wait here until the back end is free.
   wpa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_in_peak),
      .full     (q_full),
      .pop      (q_pop),
      .pop_data (q_out_peak),
      .empty    (q_empty)
   );

   // The back end searches the decade, selects the step and holds the result.
   wpa_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_empty (q_empty),
      .q_peak  (q_out_peak),
      .q_pop   (q_pop),
      .empty   (empty),
      .pop     (pop),
      .scale_uw(rsp_scale_uw),
      .peak_uw (rsp_peak_uw)
   );

endmodule

// ===== design/wpa_ram.sv =====
module wpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/wpa_front.sv =====
module wpa_front #(
   parameter int WINDOW_SIZE = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic [wpa_pkg::SAMPLE_W-1:0] sample_uw,
   output logic                   q_push,
   input  logic                   q_full,
   output logic [wpa_pkg::SAMPLE_W-1:0] q_peak
);
   import wpa_pkg::*;

   localparam int ADDR_W = $clog2(WINDOW_SIZE);
   localparam int FILL_W = $clog2(WINDOW_SIZE + 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WINDOW_SIZE - 1);
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW_SIZE);

   typedef enum logic [3:0] {
      F_IDLE  = 4'b0001,
      F_SCAN  = 4'b0010,
      F_DRAIN = 4'b0100,
      F_PUSH  = 4'b1000
   } front_state_type;

   front_state_type state_ff, state_in;
   logic [ADDR_W-1:0] write_pos_ff, write_pos_in;
   logic [ADDR_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic take_ff, take_in;
   logic [SAMPLE_W-1:0] peak_ff, peak_in;
   logic [SAMPLE_W-1:0] rd_data;
   logic accept;
   logic rd_en;

   assign accept = push && (state_ff == F_IDLE);
   assign rd_en = (state_ff == F_SCAN);

   wpa_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(WINDOW_SIZE)
   ) u_ring (
      .clock  (clock),
      .wr_en  (accept),
      .wr_addr(write_pos_ff),
      .wr_data(sample_uw),
      .rd_en  (rd_en),
      .rd_addr(scan_cnt_ff),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in = state_ff;
      write_pos_in = write_pos_ff;
      scan_cnt_in = scan_cnt_ff;
      fill_in = fill_ff;
      peak_in = peak_ff;
      take_in = 1'b0;

      // Entries beyond the fill count were never written, so they are skipped.
      if (take_ff && (rd_data > peak_ff)) begin
         peak_in = rd_data;
      end

      unique case (state_ff)
         F_IDLE: begin
            if (push) begin
               write_pos_in = (write_pos_ff == LAST_ADDR) ? '0 : write_pos_ff + 1'b1;
               if (fill_ff != FILL_MAX) begin
                  fill_in = fill_ff + 1'b1;
               end
               scan_cnt_in = '0;
               peak_in = '0;
               state_in = F_SCAN;
            end
         end
         F_SCAN: begin
            take_in = FILL_W'(scan_cnt_ff) < fill_ff;
            if (scan_cnt_ff == LAST_ADDR) begin
               state_in = F_DRAIN;
            end else begin
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end
         end
         F_DRAIN: begin
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         write_pos_ff <= '0;
         fill_ff <= '0;
         take_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         write_pos_ff <= write_pos_in;
         fill_ff <= fill_in;
         take_ff <= take_in;
      end
      scan_cnt_ff <= scan_cnt_in;
      peak_ff <= peak_in;
   end

   assign full = (state_ff != F_IDLE);
   assign q_push = (state_ff == F_PUSH) && !q_full;
   assign q_peak = peak_ff;

endmodule

// ===== design/wpa_queue.sv =====
module wpa_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [wpa_pkg::SAMPLE_W-1:0] push_data,
   output logic                   full,
   input  logic                   pop,
   output logic [wpa_pkg::SAMPLE_W-1:0] pop_data,
   output logic                   empty
);
   import wpa_pkg::*;

   logic [SAMPLE_W-1:0] slot_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];

endmodule

// ===== design/wpa_back.sv =====
module wpa_back (
   input  logic                   clock,
   input  logic                   reset,
   input  wpa_pkg::cfg_type       cfg,
   input  logic                   q_empty,
   input  logic [wpa_pkg::SAMPLE_W-1:0] q_peak,
   output logic                   q_pop,
   output logic                   empty,
   input  logic                   pop,
   output logic [wpa_pkg::SCALE_W-1:0] scale_uw,
   output logic [wpa_pkg::SAMPLE_W-1:0] peak_uw
);
   import wpa_pkg::*;

   typedef enum logic [5:0] {
      B_IDLE  = 6'b000001,
      B_MULH  = 6'b000010,
      B_CHECK = 6'b000100,
      B_MULM  = 6'b001000,
      B_MULL  = 6'b010000,
      B_OUT   = 6'b100000
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [DECADE_W-1:0] decade_ff, decade_in;
   logic [SAMPLE_W-1:0] peak_ff, peak_in;
   logic [PROD_W-1:0] prod_hi_ff, prod_hi_in;
   logic [PROD_W-1:0] prod_mid_ff, prod_mid_in;
   logic [PROD_W-1:0] prod_low_ff, prod_low_in;
   logic out_valid_ff, out_valid_in;
   logic [SCALE_W-1:0] out_scale_ff, out_scale_in;
   logic [SAMPLE_W-1:0] out_peak_ff, out_peak_in;

   logic [STEP_W-1:0] mul_step;
   logic [PROD_W-1:0] mul_out;
   logic [PROD_W-1:0] peak_wide;
   logic [PROD_W-1:0] sel_scale;
   logic out_free;

   assign peak_wide = PROD_W'(peak_ff);
   assign out_free = !out_valid_ff || pop;

   // One shared multiplier serves the decade search and both lower steps.
   always_comb begin
      mul_step = cfg.range_high;
      if (state_ff == B_MULM) begin
         mul_step = cfg.range_mid;
      end else if (state_ff == B_MULL) begin
         mul_step = cfg.range_low;
      end
      mul_out = PROD_W'(decade_ff) * PROD_W'(mul_step);
   end

   always_comb begin
      if (peak_wide >= prod_mid_ff) begin
         sel_scale = prod_hi_ff;
      end else if (peak_wide >= prod_low_ff) begin
         sel_scale = prod_mid_ff;
      end else begin
         sel_scale = prod_low_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      decade_in = decade_ff;
      peak_in = peak_ff;
      prod_hi_in = prod_hi_ff;
      prod_mid_in = prod_mid_ff;
      prod_low_in = prod_low_ff;
      out_valid_in = out_valid_ff && !pop;
      out_scale_in = out_scale_ff;
      out_peak_in = out_peak_ff;
      q_pop = 1'b0;

      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               peak_in = q_peak;
               decade_in = cfg.log_detector ? DECADE_LOG_START : DECADE_LIN_START;
               state_in = B_MULH;
            end
         end
         B_MULH: begin
            prod_hi_in = mul_out;
            state_in = B_CHECK;
         end
         B_CHECK: begin
            if ((prod_hi_ff < peak_wide) && (decade_ff < DECADE_CAP)) begin
               decade_in = (decade_ff << 3) + (decade_ff << 1);
               state_in = B_MULH;
            end else begin
               state_in = B_MULM;
            end
         end
         B_MULM: begin
            prod_mid_in = mul_out;
            state_in = B_MULL;
         end
         B_MULL: begin
            prod_low_in = mul_out;
            state_in = B_OUT;
         end
         B_OUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_scale_in = (sel_scale[PROD_W-1:SCALE_W] != '0) ?
                              SCALE_MAX : sel_scale[SCALE_W-1:0];
               out_peak_in = peak_ff;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
      decade_ff <= decade_in;
      peak_ff <= peak_in;
      prod_hi_ff <= prod_hi_in;
      prod_mid_ff <= prod_mid_in;
      prod_low_ff <= prod_low_in;
      out_scale_ff <= out_scale_in;
      out_peak_ff <= out_peak_in;
   end

   assign empty = !out_valid_ff;
   assign scale_uw = out_scale_ff;
   assign peak_uw = out_peak_ff;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the peak-hold autoranging core. A sample process
// offers power samples on the push/full side, a receive process pops results
// on the empty/pop side, and every result is compared with an autorange
// prediction that keeps its own copy of the sample ring and the step registers.
module tb;
   import wpa_pkg::*;

   localparam int RING_DEPTH = 16;
   localparam int RING_IDX_W = $clog2(RING_DEPTH);
   // Front end plus back end plus the queue between them, with margin.
   localparam int DRAIN_SLACK = 2 * (RING_DEPTH + 3) + 40;
   localparam int HOLD_CYCLES = 600;
   localparam int IDLE_PERCENT = 23;
   localparam longint CYCLE_LIMIT = 1000000;
   localparam int REPORT_LIMIT = 10;
   localparam int STREAM_ITEMS = 200;
   localparam int BACKPRESSURE_ITEMS = 80;
   localparam int PHASE_COUNT = 7;
   localparam int PHASE_ITEMS = 230;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = CSR_INDEX_W'(8'hFF);

   typedef struct packed {
      logic [SCALE_W-1:0]  scale_uw;
      logic [SAMPLE_W-1:0] peak_uw;
   } range_result_type;

   logic                   clock;
   logic                   reset;
   logic                   push;
   logic                   full;
   logic [SAMPLE_W-1:0]    req_sample_uw;
   logic                   empty;
   logic                   pop = 1'b0;
   logic [SCALE_W-1:0]     rsp_scale_uw;
   logic [SAMPLE_W-1:0]    rsp_peak_uw;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // Prediction state: a private copy of the ring, its write position and the
   // step registers, updated as samples and register writes transfer.
   logic [SAMPLE_W-1:0]   ring_copy [RING_DEPTH];
   logic [RING_IDX_W-1:0] ring_wr = '0;
   cfg_type               range_cfg = CFG_RESET;
   range_result_type      expected_ranges [$];
   range_result_type      oldest_range;

   int     failures = 0;
   longint cycle_count = 0;
   bit     sender_steady = 1'b0;
   bit     receiver_steady = 1'b0;
   // A hold-off is requested by toggling hold_req; the receiver notes it in hold_ack.
   bit     hold_req = 1'b0;
   bit     hold_ack = 1'b0;
   int     hold_left = 0;

   window_peak_autorange_core #(
      .WINDOW_SIZE(RING_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_sample_uw(req_sample_uw),
      .empty(empty),
      .pop(pop),
      .rsp_scale_uw(rsp_scale_uw),
      .rsp_peak_uw(rsp_peak_uw),
      .valid(valid),
      .ready(ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Writes the sample into the ring copy, scans it for the peak, grows the
   // decade until the high step covers the peak (bounded at the decade cap so
   // a zero high step cannot loop forever), then picks the step that fits.
   function automatic range_result_type autorange(input logic [SAMPLE_W-1:0] sample);
      range_result_type r;
      logic [SAMPLE_W-1:0] peak;
      logic [63:0] decade;
      logic [63:0] scale;
      ring_copy[ring_wr] = sample;
      ring_wr = (ring_wr == RING_IDX_W'(RING_DEPTH - 1)) ? '0 : ring_wr + 1'b1;
      peak = '0;
      foreach (ring_copy[i])
         if (ring_copy[i] > peak)
            peak = ring_copy[i];
      decade = range_cfg.log_detector ? 64'd1 : 64'd10000;
      while (decade * range_cfg.range_high < peak && decade < DECADE_CAP)
         decade = decade * 10;
      if (peak >= decade * range_cfg.range_mid)
         scale = decade * range_cfg.range_high;
      else if (peak >= decade * range_cfg.range_low)
         scale = decade * range_cfg.range_mid;
      else
         scale = decade * range_cfg.range_low;
      // The full-scale value saturates at the output width.
      if (scale > SCALE_MAX)
         scale = SCALE_MAX;
      r.scale_uw = scale[SCALE_W-1:0];
      r.peak_uw = peak;
      return r;
   endfunction

   // Offers one sample, with random idle cycles ahead of it unless the sender
   // runs steady. Push is left high after the transfer so that back-to-back
   // samples keep it asserted without a drop in the same time step.
   task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
      while (!sender_steady && $urandom_range(99) < IDLE_PERCENT) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_sample_uw <= sample;
      do @(posedge clock); while (full);
      expected_ranges.push_back(autorange(sample));
   endtask

   // Lets every outstanding result come out, then waits out the pipeline so
   // the core is idle before any register write.
   task automatic drain_results();
      push <= 1'b0;
      while (expected_ranges.size() != 0)
         @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!ready);
      // Only the low bits that a register holds are kept; unknown indexes
      // leave everything as it was.
      case (index)
         CSR_LOG_DETECTOR: range_cfg.log_detector = data[0];
         CSR_RANGE_LOW: range_cfg.range_low = data;
         CSR_RANGE_MID: range_cfg.range_mid = data;
         CSR_RANGE_HIGH: range_cfg.range_high = data;
         default: ;
      endcase
      valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_ranges(input logic log_mode, input logic [STEP_W-1:0] step_lo,
                                 input logic [STEP_W-1:0] step_mid,
                                 input logic [STEP_W-1:0] step_hi);
      write_register(CSR_LOG_DETECTOR, CSR_DATA_W'(log_mode));
      write_register(CSR_RANGE_LOW, step_lo);
      write_register(CSR_RANGE_MID, step_mid);
      write_register(CSR_RANGE_HIGH, step_hi);
   endtask

   // Step sets: the usual 1-2-5 ladder scaled, ascending random steps, fully
   // random steps (possibly out of order) and the extremes of the field.
   task automatic pick_random_ranges();
      logic [STEP_W-1:0] unit;
      logic [STEP_W-1:0] step_lo;
      logic [STEP_W-1:0] step_mid;
      logic [STEP_W-1:0] step_hi;
      case ($urandom_range(3))
         0: begin
            case ($urandom_range(3))
               0: unit = 1;
               1: unit = 10;
               2: unit = 100;
               default: unit = 1000;
            endcase
            step_lo = unit;
            step_mid = STEP_W'(2 * unit);
            step_hi = STEP_W'(5 * unit);
         end
         1: begin
            step_lo = STEP_W'($urandom_range(100, 1));
            step_mid = step_lo + STEP_W'($urandom_range(1000));
            step_hi = step_mid + STEP_W'($urandom_range(20000));
         end
         2: begin
            step_lo = STEP_W'($urandom);
            step_mid = STEP_W'($urandom);
            step_hi = STEP_W'($urandom);
         end
         default: begin
            step_lo = $urandom_range(1) ? '1 : STEP_W'(1);
            step_mid = $urandom_range(1) ? '1 : STEP_W'(1);
            step_hi = $urandom_range(1) ? '1 : STEP_W'(1);
         end
      endcase
      program_ranges(1'($urandom_range(1)), step_lo, step_mid, step_hi);
   endtask

   // Mostly log-spread magnitudes capped per phase, some values right at a
   // decade times a step (one below, on, one above), and some zeros so that
   // old peaks fall out of the window.
   function automatic logic [SAMPLE_W-1:0] draw_sample(input int max_bits);
      longint unsigned decade;
      longint unsigned edge_value;
      logic [STEP_W-1:0] step;
      int k;
      case ($urandom_range(9))
         0, 1: begin
            decade = 1;
            k = $urandom_range(9);
            repeat (k) decade = decade * 10;
            case ($urandom_range(2))
               0: step = range_cfg.range_low;
               1: step = range_cfg.range_mid;
               default: step = range_cfg.range_high;
            endcase
            edge_value = decade * step + $urandom_range(2);
            edge_value = (edge_value == 0) ? 0 : edge_value - 1;
            if (edge_value > 64'hFFFF_FFFF)
               return $urandom;
            return edge_value[SAMPLE_W-1:0];
         end
         9: return '0;
         default: return $urandom >> (SAMPLE_W - $urandom_range(max_bits, 1));
      endcase
      return '0;
   endfunction

   // With the reset steps: an empty window, values on and around the step
   // boundaries of the first decade, the largest sample, and then enough
   // small samples to push the largest one out of the window again.
   task automatic test_window_directed();
      send_sample(32'd0);
      send_sample(32'd1);
      send_sample(32'd2);
      send_sample(32'd5);
      send_sample(32'd6);
      send_sample(32'hFFFF_FFFF);
      repeat (RING_DEPTH) send_sample(32'd7);
      drain_results();
   endtask

   task automatic test_corner_registers();
      // Only bit zero of the detector register counts, so this selects the
      // linear start. A zero high step runs the decade up to its cap, and the
      // chosen step there overflows the output and must saturate.
      write_register(CSR_LOG_DETECTOR, 16'hFFFE);
      write_register(CSR_RANGE_HIGH, '0);
      write_register(CSR_RANGE_MID, '1);
      write_register(CSR_RANGE_LOW, '1);
      send_sample(32'hFFFF_FFFF);
      send_sample(32'd3);
      drain_results();
      // Steps out of order are used as given.
      program_ranges(1'b1, 16'd50000, 16'd3, 16'd7);
      repeat (RING_DEPTH) send_sample(32'd40);
      drain_results();
      // A write to an index with no register behind it changes nothing.
      write_register(CSR_UNUSED, '1);
      send_sample(32'd123456);
      drain_results();
   endtask

   // A stretch with no idling on either side.
   task automatic test_steady_stream();
      pick_random_ranges();
      sender_steady = 1'b1;
      receiver_steady = 1'b1;
      repeat (STREAM_ITEMS) send_sample(draw_sample(SAMPLE_W));
      sender_steady = 1'b0;
      receiver_steady = 1'b0;
      drain_results();
   endtask

   // The receiver stops popping for a long stretch while samples keep coming,
   // so the output register, the back end and the queue fill up and full
   // must hold the sender off without losing anything.
   task automatic test_receiver_backpressure();
      pick_random_ranges();
      sender_steady = 1'b1;
      hold_req = !hold_req;
      repeat (BACKPRESSURE_ITEMS) send_sample(draw_sample(SAMPLE_W));
      sender_steady = 1'b0;
      drain_results();
   endtask

   task automatic test_random_settings();
      int max_bits;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase == 0)
            program_ranges(1'b0, '1, '1, '1);
         else if (phase == 1)
            program_ranges(1'b1, STEP_W'(1), STEP_W'(1), STEP_W'(1));
         else
            pick_random_ranges();
         case ($urandom_range(3))
            0: max_bits = 4;
            1: max_bits = 12;
            2: max_bits = 20;
            default: max_bits = SAMPLE_W;
         endcase
         repeat (PHASE_ITEMS) send_sample(draw_sample(max_bits));
         drain_results();
      end
   endtask

   // Receive side: pops at random, steadily, or not at all during a hold-off.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            pop <= 1'b0;
         end else begin
            pop <= receiver_steady || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // Every transferred result is matched against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (expected_ranges.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("unexpected result: scale %0d peak %0d", rsp_scale_uw, rsp_peak_uw);
         end else begin
            oldest_range = expected_ranges.pop_front();
            if (rsp_scale_uw !== oldest_range.scale_uw || rsp_peak_uw !== oldest_range.peak_uw)
            begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("range mismatch: expected scale %0d peak %0d, got scale %0d peak %0d",
                           oldest_range.scale_uw, oldest_range.peak_uw,
                           rsp_scale_uw, rsp_peak_uw);
            end
         end
      end
   end

   // Watchdog for a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[window_peak_autorange_core] ERROR");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      push = 1'b0;
      req_sample_uw = '0;
      valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      foreach (ring_copy[i])
         ring_copy[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_window_directed();
      test_corner_registers();
      test_steady_stream();
      test_receiver_backpressure();
      test_random_settings();
      drain_results();

      if (failures == 0 && expected_ranges.size() == 0) begin
         $display("[window_peak_autorange_core] OK");
      end else begin
         $display("[window_peak_autorange_core] ERROR");
      end
      $finish;
   end

endmodule
